>>> rtl/cle_pkg.sv
// Shared types and constants for the cursor list engine.
`timescale 1ns / 1ps

package cle_pkg;

  localparam int unsigned CAPACITY_DEF  = 16;
  localparam int unsigned WORD_BITS_DEF = 32;

  localparam int unsigned IN_BITS  = 40;
  localparam int unsigned OUT_BITS = 144;

  typedef enum logic [3:0] {
    CMD_CLEAR     = 4'd0,
    CMD_FRONT     = 4'd1,
    CMD_BACK      = 4'd2,
    CMD_PREV      = 4'd3,
    CMD_NEXT      = 4'd4,
    CMD_SET       = 4'd5,
    CMD_PREPEND   = 4'd6,
    CMD_APPEND    = 4'd7,
    CMD_BEFORE    = 4'd8,
    CMD_AFTER     = 4'd9,
    CMD_DEL       = 4'd10,
    CMD_DEL_FRONT = 4'd11,
    CMD_DEL_BACK  = 4'd12,
    CMD_READ      = 4'd13
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_NONE = 2'd1,
    STAT_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_LOAD = 2'd1,
    CELL_INS  = 2'd2,
    CELL_DEL  = 2'd3
  } cell_op_e;

endpackage

>>> rtl/cle_cell.sv
// One storage cell of the list row: holds a word, shifts with its neighbors.
`timescale 1ns / 1ps

module cle_cell import cle_pkg::*; #(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  parameter int unsigned IW        = 4,
  parameter int unsigned IDX       = 0
) (
  input  logic                 clk_i,
  input  cell_op_e             op_i,
  input  logic [IW-1:0]        pos_i,
  input  logic [WORD_BITS-1:0] value_i,
  input  logic [WORD_BITS-1:0] left_i,
  input  logic [WORD_BITS-1:0] right_i,
  input  logic [IW-1:0]        cur_idx_i,
  input  logic [IW-1:0]        last_idx_i,
  input  logic [IW-1:0]        take_idx_i,
  output logic [WORD_BITS-1:0] word_o,
  output logic [WORD_BITS-1:0] cur_hit_o,
  output logic [WORD_BITS-1:0] last_hit_o,
  output logic [WORD_BITS-1:0] take_hit_o
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [WORD_BITS-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    case (op_i)
      CELL_LOAD: begin
        if (MY_IDX == pos_i) word_d = value_i;
      end
      CELL_INS: begin
        if (MY_IDX == pos_i) begin
          word_d = value_i;
        end else if (MY_IDX > pos_i) begin
          word_d = left_i;
        end
      end
      CELL_DEL: begin
        if (MY_IDX >= pos_i) word_d = right_i;
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o     = word_q;
  assign cur_hit_o  = {WORD_BITS{MY_IDX == cur_idx_i}} & word_q;
  assign last_hit_o = {WORD_BITS{MY_IDX == last_idx_i}} & word_q;
  assign take_hit_o = {WORD_BITS{MY_IDX == take_idx_i}} & word_q;

endmodule

>>> rtl/cursor_list_engine.sv
// Cursor list engine: bounded word list with cursor, held in a shifting cell row.
//
// Usage: one command beat enters on the s_axis channel; one report beat leaves
// on the m_axis channel for every command.
// Input tdata: command [3:0], value [35:4], zero fill [39:36].
// Output tdata: status, count, cursor_defined, cursor_position, cursor_word,
// first_word, last_word, removed_word, packed from bit 0 up, zero filled.
// A command accepted at a clock edge updates the cell row and the cursor at
// that edge; its report is registered in S_REPORT once the output register
// is free, and is valid on m_axis from then on.
// Inserts and deletes move all cells at the accepting edge; S_REPORT then
// selects cursor and back words out of the row into the output register. No
// new command is taken until that report has been registered.
// s_axis_tready_o drops for the report cycle and stays low while an earlier
// report is still waiting in the output register and the receiver stalls.
// A new command may be taken while a report waits for m_axis_tready_i.
// Reset: the list is empty, the cursor undefined, no report pending. Cell
// contents are not reset; only cells below the count are ever reported.
`timescale 1ns / 1ps

module cursor_list_engine import cle_pkg::*; #(
  parameter int unsigned CAPACITY  = CAPACITY_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // command [3:0], value [35:4], zero [39:36]
  input  logic [IN_BITS-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // status [1:0], count [6:2], cursor_defined [7], cursor_position [11:8],
  // cursor_word [43:12], first_word [75:44], last_word [107:76],
  // removed_word [139:108], zero [143:140]
  output logic [OUT_BITS-1:0] m_axis_tdata_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic {
    S_IDLE,
    S_REPORT
  } state_e;

  state_e state_q;

  logic [CW-1:0] fill_q, fill_d;
  logic [IW-1:0] cur_at_q, cur_at_d;
  logic          cur_on_q, cur_on_d;
  status_e       status_q, status_d;
  logic [WORD_BITS-1:0] removed_q, removed_d;
  logic                 out_valid_q;
  logic [OUT_BITS-1:0]  out_data_q;

  logic                 accept;
  cmd_e                 cmd;
  logic [WORD_BITS+31:0] value_ext;
  logic [WORD_BITS-1:0] value_w;
  cell_op_e             op_dec, cell_op;
  logic [IW-1:0]        pos, take_idx, last_idx, at_p1, at_m1;
  logic [CW-1:0]        fill_m1, fill_p1, at_p1_c;
  logic                 full, empty;

  logic [WORD_BITS-1:0] cell_word [CAPACITY];
  logic [WORD_BITS-1:0] cur_hit   [CAPACITY];
  logic [WORD_BITS-1:0] last_hit  [CAPACITY];
  logic [WORD_BITS-1:0] take_hit  [CAPACITY];
  logic [WORD_BITS-1:0] cur_sel, last_sel, take_sel;

  logic [WORD_BITS-1:0]  cur_w, first_w, last_w;
  logic [WORD_BITS+31:0] cur_ext, first_ext, last_ext, removed_ext;
  logic [CW+4:0]         count_ext;
  logic [IW+3:0]         pos_ext;
  logic                  out_free;
  logic [OUT_BITS-1:0]   report;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;

  assign value_ext = {{WORD_BITS{s_axis_tdata_i[35]}}, s_axis_tdata_i[35:4]};
  assign value_w   = value_ext[WORD_BITS-1:0];

  always_comb begin
    cmd       = cmd_e'(s_axis_tdata_i[3:0]);
    fill_m1   = fill_q - CW'(1);
    fill_p1   = fill_q + CW'(1);
    last_idx  = fill_m1[IW-1:0];
    at_p1_c   = CW'(cur_at_q) + CW'(1);
    at_p1     = cur_at_q + IW'(1);
    at_m1     = cur_at_q - IW'(1);
    full      = (fill_q == CW'(CAPACITY));
    empty     = (fill_q == '0);
    op_dec    = CELL_HOLD;
    pos       = '0;
    take_idx  = '0;
    status_d  = STAT_OK;
    fill_d    = fill_q;
    cur_on_d  = cur_on_q;
    cur_at_d  = cur_at_q;
    unique case (cmd)
      CMD_CLEAR: begin
        fill_d   = '0;
        cur_on_d = 1'b0;
      end
      CMD_FRONT: begin
        if (!empty) begin
          cur_on_d = 1'b1;
          cur_at_d = '0;
        end
      end
      CMD_BACK: begin
        if (!empty) begin
          cur_on_d = 1'b1;
          cur_at_d = last_idx;
        end
      end
      CMD_PREV: begin
        if (cur_on_q) begin
          if (cur_at_q == '0) cur_on_d = 1'b0;
          else cur_at_d = at_m1;
        end
      end
      CMD_NEXT: begin
        if (cur_on_q) begin
          if (at_p1_c < fill_q) cur_at_d = at_p1;
          else cur_on_d = 1'b0;
        end
      end
      CMD_SET: begin
        if (!cur_on_q) begin
          status_d = STAT_NONE;
        end else begin
          op_dec = CELL_LOAD;
          pos    = cur_at_q;
        end
      end
      CMD_PREPEND: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          op_dec = CELL_INS;
          pos    = '0;
          fill_d = fill_p1;
          if (cur_on_q) cur_at_d = at_p1;
        end
      end
      CMD_APPEND: begin
        if (full) begin
          status_d = STAT_FULL;
        end else begin
          op_dec = CELL_INS;
          pos    = fill_q[IW-1:0];
          fill_d = fill_p1;
        end
      end
      CMD_BEFORE: begin
        if (!cur_on_q) begin
          status_d = STAT_NONE;
        end else if (full) begin
          status_d = STAT_FULL;
        end else begin
          op_dec   = CELL_INS;
          pos      = cur_at_q;
          fill_d   = fill_p1;
          cur_at_d = at_p1;
        end
      end
      CMD_AFTER: begin
        if (!cur_on_q) begin
          status_d = STAT_NONE;
        end else if (full) begin
          status_d = STAT_FULL;
        end else begin
          op_dec = CELL_INS;
          pos    = at_p1;
          fill_d = fill_p1;
        end
      end
      CMD_DEL: begin
        if (!cur_on_q) begin
          status_d = STAT_NONE;
        end else begin
          op_dec   = CELL_DEL;
          pos      = cur_at_q;
          take_idx = cur_at_q;
          fill_d   = fill_m1;
          cur_on_d = 1'b0;
        end
      end
      CMD_DEL_FRONT: begin
        if (empty) begin
          status_d = STAT_NONE;
        end else begin
          op_dec   = CELL_DEL;
          pos      = '0;
          take_idx = '0;
          fill_d   = fill_m1;
          if (cur_on_q) begin
            if (cur_at_q == '0) cur_on_d = 1'b0;
            else cur_at_d = at_m1;
          end
        end
      end
      CMD_DEL_BACK: begin
        if (empty) begin
          status_d = STAT_NONE;
        end else begin
          op_dec   = CELL_DEL;
          pos      = last_idx;
          take_idx = last_idx;
          fill_d   = fill_m1;
          if (cur_on_q && cur_at_q == last_idx) cur_on_d = 1'b0;
        end
      end
      default: begin
        op_dec = CELL_HOLD;
      end
    endcase
    if (!cur_on_d || CW'(cur_at_d) >= fill_d) begin
      cur_on_d = 1'b0;
      cur_at_d = '0;
    end
  end

  assign cell_op = accept ? op_dec : CELL_HOLD;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = cell_word[g];
    end else begin : g_mid_l
      assign left_w = cell_word[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = cell_word[g];
    end else begin : g_mid_r
      assign right_w = cell_word[g+1];
    end
    cle_cell #(
      .WORD_BITS(WORD_BITS),
      .IW       (IW),
      .IDX      (g)
    ) u_cell (
      .clk_i     (clk_i),
      .op_i      (cell_op),
      .pos_i     (pos),
      .value_i   (value_w),
      .left_i    (left_w),
      .right_i   (right_w),
      .cur_idx_i (cur_at_q),
      .last_idx_i(last_idx),
      .take_idx_i(take_idx),
      .word_o    (cell_word[g]),
      .cur_hit_o (cur_hit[g]),
      .last_hit_o(last_hit[g]),
      .take_hit_o(take_hit[g])
    );
  end

  always_comb begin
    cur_sel  = '0;
    last_sel = '0;
    take_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      cur_sel  = cur_sel | cur_hit[i];
      last_sel = last_sel | last_hit[i];
      take_sel = take_sel | take_hit[i];
    end
  end

  assign removed_d = (op_dec == CELL_DEL) ? take_sel : '0;

  assign cur_w       = cur_on_q ? cur_sel : '0;
  assign first_w     = empty ? '0 : cell_word[0];
  assign last_w      = empty ? '0 : last_sel;
  assign cur_ext     = {{32{cur_w[WORD_BITS-1]}}, cur_w};
  assign first_ext   = {{32{first_w[WORD_BITS-1]}}, first_w};
  assign last_ext    = {{32{last_w[WORD_BITS-1]}}, last_w};
  assign removed_ext = {{32{removed_q[WORD_BITS-1]}}, removed_q};
  assign count_ext   = {5'd0, fill_q};
  assign pos_ext     = {4'd0, cur_at_q};

  assign report = {4'd0, removed_ext[31:0], last_ext[31:0], first_ext[31:0],
                   cur_ext[31:0], pos_ext[3:0], cur_on_q, count_ext[4:0],
                   status_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      cur_on_q    <= 1'b0;
      cur_at_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (m_axis_tready_i) out_valid_q <= 1'b0;
          if (accept) begin
            fill_q   <= fill_d;
            cur_on_q <= cur_on_d;
            cur_at_q <= cur_at_d;
            state_q  <= S_REPORT;
          end
        end
        S_REPORT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      removed_q <= removed_d;
    end
    if (state_q == S_REPORT && out_free) begin
      out_data_q <= report;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

>>> rtl/cle_checker.sv
// Port-level checks for the cursor list engine, bound to the top level.
`timescale 1ns / 1ps

module cle_checker import cle_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OUT_BITS-1:0] m_axis_tdata_o
);

  // stalled report beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("report beat changed under stall");

  // one command in flight
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("command taken during report cycle");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[1:0] != 2'd3)
    else $error("bad status code");

  // undefined cursor reports zero position and word
  a_no_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[7]
      |-> m_axis_tdata_o[11:8] == 4'd0 && m_axis_tdata_o[43:12] == 32'd0)
    else $error("undefined cursor with nonzero fields");

  // failed command removes nothing
  a_fail_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1:0] != 2'd0 |-> m_axis_tdata_o[139:108] == 32'd0)
    else $error("failed command reports a removed word");

endmodule

bind cursor_list_engine cle_checker u_cle_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);
